@@ design/gtlmo_pkg.sv @@
package gtlmo_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam logic signed [31:0] LAT_LIMIT   = 32'sd1509949440;
    localparam logic signed [31:0] DEG2RAD_Q36 = 32'sd1199381129;
    localparam logic signed [31:0] CORDIC_X0   = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    localparam logic signed [65:0] CM1_TERM = 66'sd7283207045 <<< 30;
    localparam logic signed [26:0] CM2 = -27'sd36688364;
    localparam logic signed [17:0] CM3 = 18'sd77005;
    localparam logic signed [8:0]  CM4 = -9'sd151;
    localparam logic signed [33:0] CP1 = 34'sd7301551882;
    localparam logic signed [23:0] CP2 = -24'sd6127616;
    localparam logic signed [14:0] CP3 = 15'sd7733;

    localparam logic [1:0] REG_ORIGIN_LAT = 2'd0;
    localparam logic [1:0] REG_ORIGIN_LON = 2'd1;

    typedef struct packed {
        logic signed [32:0] dlat;
        logic signed [33:0] dlon;
    } delta_t;

    typedef struct packed {
        delta_t             d;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cordic_t;

    typedef struct packed {
        delta_t           d;
        logic [6:0][31:0] c;
    } cheb_t;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd843314857;
            5'd1:  r = 32'sd497837829;
            5'd2:  r = 32'sd263043837;
            5'd3:  r = 32'sd133525159;
            5'd4:  r = 32'sd67021687;
            5'd5:  r = 32'sd33543516;
            5'd6:  r = 32'sd16775851;
            5'd7:  r = 32'sd8388437;
            5'd8:  r = 32'sd4194283;
            5'd9:  r = 32'sd2097149;
            5'd31: r = 32'sd0;
            default: r = 32'sd1 <<< (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

@@ design/gps_to_local_metric_offset_top.sv @@
// Throughput is one beat per cycle while m_ready is high; a stalled result stalls only the full stages behind it.
// The pipeline is one input stage, one CORDIC cell per step, five recurrence cells,
// and four stages for the series products, sums, distance products and rounding.
// Synchronous active-low reset empties the pipeline and sets both origins to zero.
module gps_to_local_metric_offset_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [32:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_lat,
    input  logic signed [32:0] s_point_lon,
    input  logic signed [31:0] s_scale_lat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [33:0] m_north_dist,
    output logic signed [34:0] m_east_dist,
    output logic [24:0]        m_lat_scale,
    output logic signed [25:0] m_lon_scale
);
    localparam int N = gtlmo_pkg::CORDIC_STEPS;

    logic signed [31:0] origin_lat_reg;
    logic signed [32:0] origin_lon_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_lat_reg <= '0;
            origin_lon_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                gtlmo_pkg::REG_ORIGIN_LAT: origin_lat_reg <= cfg_data[31:0];
                gtlmo_pkg::REG_ORIGIN_LON: origin_lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                cv [0:N];
    logic                cr [0:N];
    gtlmo_pkg::cordic_t  cd [0:N];
    gtlmo_pkg::cordic_t  s0_next;
    logic signed [31:0]  slat;
    logic signed [63:0]  zprod;
    logic                v0_reg;
    gtlmo_pkg::cordic_t  d0_reg;

    always_comb begin
        slat = s_scale_lat;
        if (s_scale_lat > gtlmo_pkg::LAT_LIMIT) begin
            slat = gtlmo_pkg::LAT_LIMIT;
        end else if (s_scale_lat < -gtlmo_pkg::LAT_LIMIT) begin
            slat = -gtlmo_pkg::LAT_LIMIT;
        end
        zprod = slat * gtlmo_pkg::DEG2RAD_Q36;
        s0_next.z = 32'((zprod + 64'sd536870912) >>> 30);
        s0_next.x = gtlmo_pkg::CORDIC_X0;
        s0_next.y = '0;
        s0_next.d.dlat = 33'(s_point_lat) - 33'(origin_lat_reg);
        s0_next.d.dlon = 34'(s_point_lon) - 34'(origin_lon_reg);
    end

    assign s_ready = !v0_reg || cr[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            d0_reg <= s0_next;
        end
    end

    assign cv[0] = v0_reg;
    assign cd[0] = d0_reg;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        gtlmo_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (5'(i)),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_data  (cd[i+1])
        );
    end

    logic              hv [0:5];
    logic              hr [0:5];
    gtlmo_pkg::cheb_t  hd [0:5];

    always_comb begin
        hd[0].d    = cd[N].d;
        hd[0].c    = '0;
        hd[0].c[0] = gtlmo_pkg::ONE_Q30;
        hd[0].c[1] = cd[N].x;
    end
    assign hv[0] = cv[N];
    assign cr[N] = hr[0];

    for (genvar k = 0; k < 5; k++) begin : g_cheb
        gtlmo_cheb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .n         (3'(k + 1)),
            .in_valid  (hv[k]),
            .in_ready  (hr[k]),
            .in_data   (hd[k]),
            .out_valid (hv[k+1]),
            .out_ready (hr[k+1]),
            .out_data  (hd[k+1])
        );
    end

    logic                vp_reg, vq_reg, vd_reg, vo_reg;
    logic                rp, rq, rd, ro;
    gtlmo_pkg::delta_t   dp_reg, dq_reg;
    logic signed [65:0]  p2_reg, p4_reg, p6_reg, p1_reg, p3_reg, p5_reg;
    logic signed [29:0]  latq_reg, lonq_reg;
    logic signed [65:0]  pn_reg, pe_reg;
    logic signed [29:0]  lats_reg, lons_reg;
    logic signed [65:0]  sum_lat, sum_lon;
    logic signed [29:0]  latq_next, lonq_next;
    logic signed [33:0]  north_reg;
    logic signed [34:0]  east_reg;
    logic [24:0]         lat_scale_reg;
    logic signed [25:0]  lon_scale_reg;
    logic signed [65:0]  north_full, east_full;

    assign ro = !vo_reg || m_ready;
    assign rd = !vd_reg || ro;
    assign rq = !vq_reg || rd;
    assign rp = !vp_reg || rq;
    assign hr[5] = rp;

    always_comb begin
        sum_lat = gtlmo_pkg::CM1_TERM + p2_reg + p4_reg + p6_reg;
        sum_lon = p1_reg + p3_reg + p5_reg;
        latq_next = 30'((sum_lat + 66'sd8589934592) >>> 34);
        lonq_next = 30'((sum_lon + 66'sd8589934592) >>> 34);
        north_full = (pn_reg + 66'sd134217728) >>> 28;
        east_full  = (pe_reg + 66'sd134217728) >>> 28;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rp) vp_reg <= hv[5];
            if (rq) vq_reg <= vp_reg;
            if (rd) vd_reg <= vq_reg;
            if (ro) vo_reg <= vd_reg;
        end
        if (rp && hv[5]) begin
            dp_reg <= hd[5].d;
            p2_reg <= gtlmo_pkg::CM2 * $signed(hd[5].c[2]);
            p4_reg <= gtlmo_pkg::CM3 * $signed(hd[5].c[4]);
            p6_reg <= gtlmo_pkg::CM4 * $signed(hd[5].c[6]);
            p1_reg <= gtlmo_pkg::CP1 * $signed(hd[5].c[1]);
            p3_reg <= gtlmo_pkg::CP2 * $signed(hd[5].c[3]);
            p5_reg <= gtlmo_pkg::CP3 * $signed(hd[5].c[5]);
        end
        if (rq && vp_reg) begin
            dq_reg   <= dp_reg;
            latq_reg <= latq_next;
            lonq_reg <= lonq_next;
        end
        if (rd && vq_reg) begin
            pn_reg   <= latq_reg * dq_reg.dlat;
            pe_reg   <= lonq_reg * dq_reg.dlon;
            lats_reg <= (latq_reg + 30'sd8) >>> 4;
            lons_reg <= (lonq_reg + 30'sd8) >>> 4;
        end
        if (ro && vd_reg) begin
            north_reg     <= north_full[33:0];
            east_reg      <= east_full[34:0];
            lat_scale_reg <= lats_reg[24:0];
            lon_scale_reg <= lons_reg[25:0];
        end
    end

    assign m_valid      = vo_reg;
    assign m_north_dist = north_reg;
    assign m_east_dist  = east_reg;
    assign m_lat_scale  = lat_scale_reg;
    assign m_lon_scale  = lon_scale_reg;
endmodule

@@ design/gtlmo_cordic_cell.sv @@
module gtlmo_cordic_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [4:0]            step,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gtlmo_pkg::cordic_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gtlmo_pkg::cordic_t    out_data
);
    logic                valid_reg;
    gtlmo_pkg::cordic_t  data_reg;
    gtlmo_pkg::cordic_t  data_next;
    logic signed [31:0]  dx;
    logic signed [31:0]  dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        dx = in_data.y >>> step;
        dy = in_data.x >>> step;
        data_next   = in_data;
        if (!in_data.z[31]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - gtlmo_pkg::atan_q30(step);
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + gtlmo_pkg::atan_q30(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

@@ design/gtlmo_cheb_cell.sv @@
module gtlmo_cheb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtlmo_pkg::cheb_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gtlmo_pkg::cheb_t    out_data
);
    logic               valid_reg;
    gtlmo_pkg::cheb_t   data_reg;
    gtlmo_pkg::cheb_t   data_next;
    logic signed [63:0] prod;
    logic signed [31:0] q;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        prod = $signed(in_data.c[1]) * $signed(in_data.c[n]);
        q    = 32'((prod + 64'sd536870912) >>> 30);
        data_next = in_data;
        data_next.c[3'(n + 3'd1)] = 32'((q <<< 1) - $signed(in_data.c[3'(n - 3'd1)]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

@@ design/gtlmo_checker.sv @@
module gtlmo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [24:0]        m_lat_scale
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_cfg: assert property (@(posedge aclk) cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lat_scale >= 25'd28000000) && (m_lat_scale <= 25'd28700000))
        else $error("latitude scale out of range");
endmodule

bind gps_to_local_metric_offset_top gtlmo_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_lat_scale (m_lat_scale)
);
